>>> design/seird_pkg.sv
package seird_pkg;

  localparam int CNT_W  = 40;
  localparam int RATE_W = 24;
  localparam int INV_W  = 32;
  localparam int FRAC_W = 32;
  localparam int P_W    = 41;
  localparam int FLUX_W = 43;
  localparam int MA_W   = 24;
  localparam int MB_W   = 41;
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = 74;
  localparam int ADDR_W = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
  localparam logic [FLUX_W-1:0] FLUX_CAP = {1'b1, {(FLUX_W-1){1'b0}}};

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_AI  = 3'd0;
  localparam cfg_idx_t REG_AE  = 3'd1;
  localparam cfg_idx_t REG_K   = 3'd2;
  localparam cfg_idx_t REG_R   = 3'd3;
  localparam cfg_idx_t REG_B   = 3'd4;
  localparam cfg_idx_t REG_M   = 3'd5;
  localparam cfg_idx_t REG_G   = 3'd6;
  localparam cfg_idx_t REG_INV = 3'd7;

  localparam logic [RATE_W-1:0] RST_AI  = 24'd167605;
  localparam logic [RATE_W-1:0] RST_AE  = 24'd167605;
  localparam logic [RATE_W-1:0] RST_K   = 24'd7046;
  localparam logic [RATE_W-1:0] RST_R   = 24'd159719;
  localparam logic [RATE_W-1:0] RST_B   = 24'd167605;
  localparam logic [RATE_W-1:0] RST_M   = 24'd3154;
  localparam logic [RATE_W-1:0] RST_G   = 24'd0;
  localparam logic [INV_W-1:0]  RST_INV = 32'd100592521;

  typedef logic [3:0] asel_t;
  localparam asel_t A_INV_LO  = 4'd0;
  localparam asel_t A_INV_HI  = 4'd1;
  localparam asel_t A_AI      = 4'd2;
  localparam asel_t A_AE      = 4'd3;
  localparam asel_t A_K       = 4'd4;
  localparam asel_t A_R       = 4'd5;
  localparam asel_t A_B       = 4'd6;
  localparam asel_t A_M       = 4'd7;
  localparam asel_t A_G       = 4'd8;
  localparam asel_t A_FRAC_LO = 4'd9;
  localparam asel_t A_FRAC_HI = 4'd10;

  typedef logic [2:0] bsel_t;
  localparam bsel_t B_S = 3'd0;
  localparam bsel_t B_E = 3'd1;
  localparam bsel_t B_I = 3'd2;
  localparam bsel_t B_R = 3'd3;
  localparam bsel_t B_P = 3'd4;

  typedef logic [3:0] wb_t;
  localparam wb_t WB_NONE   = 4'd0;
  localparam wb_t WB_ACC    = 4'd1;
  localparam wb_t WB_FRAC   = 4'd2;
  localparam wb_t WB_P_SET  = 4'd3;
  localparam wb_t WB_P_ADD  = 4'd4;
  localparam wb_t WB_FLUX   = 4'd5;
  localparam wb_t WB_EK     = 4'd6;
  localparam wb_t WB_ER     = 4'd7;
  localparam wb_t WB_IB     = 4'd8;
  localparam wb_t WB_IM     = 4'd9;
  localparam wb_t WB_RG     = 4'd10;
  localparam wb_t WB_SETTLE = 4'd11;

  typedef logic [1:0] seq_t;
  localparam seq_t SEQ_NEXT = 2'd0;
  localparam seq_t SEQ_IDLE = 2'd1;
  localparam seq_t SEQ_GOTO = 2'd2;
  localparam seq_t SEQ_EMIT = 2'd3;

  typedef logic [ADDR_W-1:0] addr_t;
  localparam addr_t ADDR_IDLE = 4'd0;
  localparam addr_t ADDR_EMIT = 4'd1;
  localparam addr_t ADDR_STEP = 4'd2;

  typedef struct packed {
    asel_t a_sel;
    bsel_t b_sel;
    wb_t   wb;
    seq_t  seq;
    addr_t target;
  } ctrl_t;

  typedef struct packed {
    logic idle;
    logic emit;
  } seq_stat_t;

  typedef struct packed {
    logic [RATE_W-1:0] ai;
    logic [RATE_W-1:0] ae;
    logic [RATE_W-1:0] k;
    logic [RATE_W-1:0] r;
    logic [RATE_W-1:0] b;
    logic [RATE_W-1:0] m;
    logic [RATE_W-1:0] g;
    logic [INV_W-1:0]  inv;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] d;
    logic [CNT_W-1:0] r;
    logic [CNT_W-1:0] i;
    logic [CNT_W-1:0] e;
    logic [CNT_W-1:0] s;
  } cnt_set_t;

  typedef struct packed {
    logic             clip;
    logic [CNT_W-1:0] val;
  } settle_t;

  function automatic settle_t settle(input logic [CNT_W-1:0] x, input logic [43:0] gain,
                                     input logic [43:0] loss);
    logic [45:0] v;
    settle_t     o;
    v = {6'b0, x} + {2'b0, gain} - {2'b0, loss};
    if (v[45]) begin
      o.clip = 1'b1;
      o.val  = '0;
    end else if (v[44:CNT_W] != '0) begin
      o.clip = 1'b1;
      o.val  = CNT_MAX;
    end else begin
      o.clip = 1'b0;
      o.val  = v[CNT_W-1:0];
    end
    return o;
  endfunction

  // Words 2 to 12 each issue a multiply whose product the next word retires.
  function automatic ctrl_t ucode(input addr_t addr);
    ctrl_t w;
    w = '{a_sel: A_AI, b_sel: B_S, wb: WB_NONE, seq: SEQ_NEXT, target: ADDR_IDLE};
    case (addr)
      ADDR_IDLE: w.seq = SEQ_IDLE;
      ADDR_EMIT: begin
        w.seq    = SEQ_EMIT;
        w.target = ADDR_IDLE;
      end
      ADDR_STEP: begin
        w.a_sel = A_INV_LO;
        w.b_sel = B_S;
      end
      4'd3: begin
        w.a_sel = A_INV_HI;
        w.b_sel = B_S;
        w.wb    = WB_ACC;
      end
      4'd4: begin
        w.a_sel = A_AI;
        w.b_sel = B_I;
        w.wb    = WB_FRAC;
      end
      4'd5: begin
        w.a_sel = A_AE;
        w.b_sel = B_E;
        w.wb    = WB_P_SET;
      end
      4'd6: begin
        w.a_sel = A_K;
        w.b_sel = B_E;
        w.wb    = WB_P_ADD;
      end
      4'd7: begin
        w.a_sel = A_FRAC_LO;
        w.b_sel = B_P;
        w.wb    = WB_EK;
      end
      4'd8: begin
        w.a_sel = A_FRAC_HI;
        w.b_sel = B_P;
        w.wb    = WB_ACC;
      end
      4'd9: begin
        w.a_sel = A_R;
        w.b_sel = B_E;
        w.wb    = WB_FLUX;
      end
      4'd10: begin
        w.a_sel = A_B;
        w.b_sel = B_I;
        w.wb    = WB_ER;
      end
      4'd11: begin
        w.a_sel = A_M;
        w.b_sel = B_I;
        w.wb    = WB_IB;
      end
      4'd12: begin
        w.a_sel = A_G;
        w.b_sel = B_R;
        w.wb    = WB_IM;
      end
      4'd13: w.wb = WB_RG;
      4'd14: begin
        w.wb     = WB_SETTLE;
        w.seq    = SEQ_GOTO;
        w.target = ADDR_EMIT;
      end
      default: begin
        w.seq    = SEQ_GOTO;
        w.target = ADDR_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> design/seird_useq.sv
module seird_useq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  action,
  input  logic                  out_room,
  output seird_pkg::ctrl_t      word,
  output seird_pkg::seq_stat_t  stat
);

  seird_pkg::addr_t upc_r;
  seird_pkg::addr_t upc_nxt;

  assign word      = seird_pkg::ucode(upc_r);
  assign stat.idle = (word.seq == seird_pkg::SEQ_IDLE);
  assign stat.emit = (word.seq == seird_pkg::SEQ_EMIT) && out_room;

  always_comb begin
    upc_nxt = upc_r;
    case (word.seq)
      seird_pkg::SEQ_IDLE: begin
        if (start) begin
          upc_nxt = (action == seird_pkg::ACT_STEP) ? seird_pkg::ADDR_STEP
                                                    : seird_pkg::ADDR_EMIT;
        end
      end
      seird_pkg::SEQ_NEXT: upc_nxt = upc_r + seird_pkg::addr_t'(1);
      seird_pkg::SEQ_GOTO: upc_nxt = word.target;
      seird_pkg::SEQ_EMIT: begin
        if (out_room) begin
          upc_nxt = word.target;
        end
      end
      default: upc_nxt = seird_pkg::ADDR_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= seird_pkg::ADDR_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

>>> design/seird_dpath.sv
module seird_dpath (
  input  logic                clk,
  input  logic                rst_n,
  input  seird_pkg::ctrl_t    word,
  input  seird_pkg::cfg_t     cfg,
  input  logic                load_en,
  input  seird_pkg::cnt_set_t load_cnt,
  output seird_pkg::cnt_set_t cnt,
  output logic                clip
);

  logic [seird_pkg::MA_W-1:0]   mul_a;
  logic [seird_pkg::MB_W-1:0]   mul_b;
  logic [seird_pkg::PROD_W-1:0] prod_nxt;
  logic [seird_pkg::PROD_W-1:0] prod_r;
  logic [seird_pkg::PROD_W-1:0] acc_r;
  logic [seird_pkg::SUM_W-1:0]  wide_sum;
  logic [49:0]                  flux_q;
  logic [seird_pkg::FLUX_W-1:0] flux_nxt;
  logic [seird_pkg::CNT_W-1:0]  shifted;
  logic [seird_pkg::P_W-1:0]    p_nxt;

  logic [seird_pkg::FRAC_W-1:0] frac_r;
  logic [seird_pkg::P_W-1:0]    p_r;
  logic [seird_pkg::FLUX_W-1:0] flux_r;
  logic [seird_pkg::CNT_W-1:0]  ek_r;
  logic [seird_pkg::CNT_W-1:0]  er_r;
  logic [seird_pkg::CNT_W-1:0]  ib_r;
  logic [seird_pkg::CNT_W-1:0]  im_r;
  logic [seird_pkg::CNT_W-1:0]  rg_r;

  seird_pkg::cnt_set_t cnt_r;
  seird_pkg::cnt_set_t cnt_nxt;
  logic                clip_r;
  logic                clip_nxt;
  seird_pkg::settle_t  st_s;
  seird_pkg::settle_t  st_e;
  seird_pkg::settle_t  st_i;
  seird_pkg::settle_t  st_r;
  seird_pkg::settle_t  st_d;

  always_comb begin
    case (word.a_sel)
      seird_pkg::A_INV_LO:  mul_a = cfg.inv[23:0];
      seird_pkg::A_INV_HI:  mul_a = {16'b0, cfg.inv[31:24]};
      seird_pkg::A_AI:      mul_a = cfg.ai;
      seird_pkg::A_AE:      mul_a = cfg.ae;
      seird_pkg::A_K:       mul_a = cfg.k;
      seird_pkg::A_R:       mul_a = cfg.r;
      seird_pkg::A_B:       mul_a = cfg.b;
      seird_pkg::A_M:       mul_a = cfg.m;
      seird_pkg::A_G:       mul_a = cfg.g;
      seird_pkg::A_FRAC_LO: mul_a = frac_r[23:0];
      seird_pkg::A_FRAC_HI: mul_a = {16'b0, frac_r[31:24]};
      default:              mul_a = '0;
    endcase
  end

  always_comb begin
    case (word.b_sel)
      seird_pkg::B_S: mul_b = {1'b0, cnt_r.s};
      seird_pkg::B_E: mul_b = {1'b0, cnt_r.e};
      seird_pkg::B_I: mul_b = {1'b0, cnt_r.i};
      seird_pkg::B_R: mul_b = {1'b0, cnt_r.r};
      seird_pkg::B_P: mul_b = p_r;
      default:        mul_b = '0;
    endcase
  end

  assign prod_nxt = {{seird_pkg::MB_W{1'b0}}, mul_a} * {{seird_pkg::MA_W{1'b0}}, mul_b};

  // The high partial product lands 24 bits up on the low one.
  assign wide_sum = {9'b0, acc_r} + {prod_r[49:0], 24'b0};
  assign flux_q   = wide_sum[73:24];
  assign flux_nxt = (flux_q > {7'b0, seird_pkg::FLUX_CAP}) ? seird_pkg::FLUX_CAP
                                                           : flux_q[42:0];
  assign shifted  = prod_r[63:24];
  assign p_nxt    = {1'b0, p_r[39:0]} + {1'b0, shifted};

  assign st_s = seird_pkg::settle(cnt_r.s, 44'd0, {1'b0, flux_r});
  assign st_e = seird_pkg::settle(cnt_r.e, {1'b0, flux_r},
                                  {3'b0, {1'b0, ek_r} + {1'b0, er_r}});
  assign st_i = seird_pkg::settle(cnt_r.i, {4'b0, ek_r},
                                  {3'b0, {1'b0, ib_r} + {1'b0, im_r}});
  assign st_r = seird_pkg::settle(cnt_r.r, {3'b0, {1'b0, ib_r} + {1'b0, er_r}},
                                  {4'b0, rg_r});
  assign st_d = seird_pkg::settle(cnt_r.d, {4'b0, im_r}, 44'd0);

  always_comb begin
    cnt_nxt  = cnt_r;
    clip_nxt = clip_r;
    if (load_en) begin
      cnt_nxt  = load_cnt;
      clip_nxt = 1'b0;
    end else if (word.wb == seird_pkg::WB_SETTLE) begin
      cnt_nxt.s = st_s.val;
      cnt_nxt.e = st_e.val;
      cnt_nxt.i = st_i.val;
      cnt_nxt.r = st_r.val;
      cnt_nxt.d = st_d.val;
      clip_nxt  = st_s.clip | st_e.clip | st_i.clip | st_r.clip | st_d.clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      clip_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      clip_r <= clip_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (word.wb)
      seird_pkg::WB_ACC:   acc_r  <= prod_r;
      seird_pkg::WB_FRAC:  frac_r <= wide_sum[71:40];
      seird_pkg::WB_P_SET: p_r    <= {1'b0, shifted};
      seird_pkg::WB_P_ADD: p_r    <= p_nxt;
      seird_pkg::WB_FLUX:  flux_r <= flux_nxt;
      seird_pkg::WB_EK:    ek_r   <= shifted;
      seird_pkg::WB_ER:    er_r   <= shifted;
      seird_pkg::WB_IB:    ib_r   <= shifted;
      seird_pkg::WB_IM:    im_r   <= shifted;
      seird_pkg::WB_RG:    rg_r   <= shifted;
      default: ;
    endcase
  end

  assign cnt  = cnt_r;
  assign clip = clip_r;

endmodule

>>> design/seird_euler_step.sv
// SEIRD compartment stepper. A load request (in_tuser 0) sets the five Q24.16 counts and
// returns them through the emit word; a step request (in_tuser 1) runs one simultaneous
// forward-Euler step in order: the dispatch from the idle word, thirteen microcode words
// that share a single 24 by 41 bit multiplier (eleven products, each retired by the word
// after the one that issued it), and an emit word that hands the result to the output
// register once it has room. Requests are taken one at a time; a result held in the
// output register does not block the next request, only the following emit.
// Configuration writes are taken in any cycle but belong only to idle periods.
module seird_euler_step (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // load_susceptible, load_exposed, load_infected, load_recovered, load_dead
  input  logic [199:0]                    in_tdata,
  // action
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_susceptible, out_exposed, out_infected, out_recovered, out_dead
  output logic [199:0]                    out_tdata,
  // clipped
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [seird_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  seird_pkg::cfg_t      cfg_r;
  seird_pkg::ctrl_t     word;
  seird_pkg::seq_stat_t stat;
  seird_pkg::cnt_set_t  load_cnt;
  seird_pkg::cnt_set_t  cnt;
  seird_pkg::cnt_set_t  out_cnt_r;
  logic                 clip;
  logic                 out_clip_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic                 out_room;
  logic                 in_acc;
  logic                 load_en;

  assign cfg_ready = 1'b1;
  assign in_tready = stat.idle;
  assign in_acc    = in_tvalid && in_tready;
  assign load_en   = in_acc && (in_tuser == seird_pkg::ACT_LOAD);
  assign out_room  = !out_valid_r || out_tready;

  assign load_cnt.s = in_tdata[39:0];
  assign load_cnt.e = in_tdata[79:40];
  assign load_cnt.i = in_tdata[119:80];
  assign load_cnt.r = in_tdata[159:120];
  assign load_cnt.d = in_tdata[199:160];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ai  <= seird_pkg::RST_AI;
      cfg_r.ae  <= seird_pkg::RST_AE;
      cfg_r.k   <= seird_pkg::RST_K;
      cfg_r.r   <= seird_pkg::RST_R;
      cfg_r.b   <= seird_pkg::RST_B;
      cfg_r.m   <= seird_pkg::RST_M;
      cfg_r.g   <= seird_pkg::RST_G;
      cfg_r.inv <= seird_pkg::RST_INV;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        seird_pkg::REG_AI:  cfg_r.ai  <= cfg_data[23:0];
        seird_pkg::REG_AE:  cfg_r.ae  <= cfg_data[23:0];
        seird_pkg::REG_K:   cfg_r.k   <= cfg_data[23:0];
        seird_pkg::REG_R:   cfg_r.r   <= cfg_data[23:0];
        seird_pkg::REG_B:   cfg_r.b   <= cfg_data[23:0];
        seird_pkg::REG_M:   cfg_r.m   <= cfg_data[23:0];
        seird_pkg::REG_G:   cfg_r.g   <= cfg_data[23:0];
        seird_pkg::REG_INV: cfg_r.inv <= cfg_data;
        default: ;
      endcase
    end
  end

  seird_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .action   (in_tuser),
    .out_room (out_room),
    .word     (word),
    .stat     (stat)
  );

  seird_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .word     (word),
    .cfg      (cfg_r),
    .load_en  (load_en),
    .load_cnt (load_cnt),
    .cnt      (cnt),
    .clip     (clip)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) begin
      out_cnt_r  <= cnt;
      out_clip_r <= clip;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r.d, out_cnt_r.r, out_cnt_r.i, out_cnt_r.e, out_cnt_r.s};
  assign out_tuser  = out_clip_r;

endmodule

>>> design/seird_chk.sv
module seird_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata,
  input logic         out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result was withdrawn while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("Result changed while stalled.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("A second request was taken before the first one finished.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Output is valid right after reset.");

endmodule

bind seird_euler_step seird_chk u_seird_chk (.*);
